/* rtl/tdoar_pkg.sv */
// ----------------------------------------------------------------------------
// tdoar_pkg
// Shared types, codes and radix table for the time-of-day add/round block.
// ----------------------------------------------------------------------------
package tdoar_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int FIELD_W    = 10;
    localparam int DELTA_W    = 48;
    localparam int ACC_W      = 48;
    localparam int NIB_W      = 4;
    localparam int DIV_STEPS  = ACC_W / NIB_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SDATA_W    = 104;
    localparam int MDATA_W    = 48;

    localparam logic [2:0] UNIT_NS   = 3'd0;
    localparam logic [2:0] UNIT_HOUR = 3'd5;

    typedef logic [FIELD_W-1:0] t_field;

    typedef enum logic [2:0] {
        ACT_LOAD  = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_ROUND = 3'd2,
        ACT_CEIL  = 3'd3,
        ACT_FLOOR = 3'd4,
        ACT_NOP   = 3'd5
    } t_act;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEG     = 2'd1,
        ST_BADLOAD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HORN,
        S_SUM,
        S_DIV,
        S_RND,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_act                       action;
        logic [2:0]                 unit;
        logic signed [DELTA_W-1:0]  delta;
        logic                       load_ok;
        t_field [NUM_FIELDS-1:0]    load;
    } t_item;

    function automatic t_field radix(input logic [2:0] k);
        t_field r;
        unique case (k)
            3'd0, 3'd1, 3'd2: r = 10'd1000;
            3'd3, 3'd4:       r = 10'd60;
            default:          r = 10'd24;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tdoar_front.sv */
// ----------------------------------------------------------------------------
// tdoar_front
// Accepts input transfers, decodes and checks them, and queues them.
// ----------------------------------------------------------------------------
module tdoar_front
    import tdoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [SDATA_W-1:0] i_s_axis_tdata,
    input  logic [2:0]         i_s_axis_tuser,
    output t_item              o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);

    t_item      w_item;
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    always_comb begin
        w_item.action = (i_s_axis_tuser > 3'd4) ? ACT_NOP : t_act'(i_s_axis_tuser);
        w_item.unit   = (i_s_axis_tdata[2:0] > UNIT_HOUR) ? UNIT_HOUR : i_s_axis_tdata[2:0];
        w_item.delta  = i_s_axis_tdata[50:3];
        w_item.load[5] = {5'd0, i_s_axis_tdata[55:51]};
        w_item.load[4] = {4'd0, i_s_axis_tdata[61:56]};
        w_item.load[3] = {4'd0, i_s_axis_tdata[67:62]};
        w_item.load[2] = i_s_axis_tdata[77:68];
        w_item.load[1] = i_s_axis_tdata[87:78];
        w_item.load[0] = i_s_axis_tdata[97:88];
        w_item.load_ok = 1'b1;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            if (w_item.load[k] >= radix(3'(k))) begin
                w_item.load_ok = 1'b0;
            end
        end
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_head_valid    = (r_cnt != 2'd0);
    assign o_head          = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

/* rtl/tdoar_back.sv */
// ----------------------------------------------------------------------------
// tdoar_back
// Executes queued operations on the time registers and drives the result.
// ----------------------------------------------------------------------------
module tdoar_back
    import tdoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [MDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser
);

    t_state                    r_state, n_state;
    t_field                    r_f [NUM_FIELDS];
    t_field                    n_f [NUM_FIELDS];
    logic [ACC_W-1:0]          r_acc, n_acc;
    t_field                    r_rem, n_rem;
    logic [2:0]                r_k, n_k;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [2:0]                r_unit, n_unit;
    t_act                      r_act, n_act;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    t_status                   r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    t_field                    r_out_f [NUM_FIELDS];
    t_status                   r_out_status;
    logic                      w_emit;
    logic                      w_ofree;
    logic [2:0]                w_rd_idx;
    t_field                    w_rd;
    logic [ACC_W:0]            w_sum;
    logic [13:0]               w_x;
    logic [NIB_W-1:0]          w_qd;
    t_field                    w_remv;
    logic                      w_inc;
    logic                      w_carry;

    function automatic logic [ACC_W-1:0] mul_radix(input logic [ACC_W-1:0] a,
                                                   input logic [2:0] k);
        logic [ACC_W-1:0] p;
        if (k < 3'd3) begin
            p = (a << 10) - (a << 4) - (a << 3);
        end else begin
            p = (a << 6) - (a << 2);
        end
        return p;
    endfunction

    assign w_ofree  = !r_out_valid || i_m_axis_tready;
    assign w_rd_idx = (r_state == S_HORN) ? r_k - 3'd1 : r_k;
    assign w_rd     = r_f[w_rd_idx];
    assign w_sum    = {1'b0, r_acc} + {r_delta[DELTA_W-1], r_delta};
    assign w_x      = {r_rem[9:0], r_acc[ACC_W-1 -: NIB_W]};

    always_comb begin
        w_qd   = '0;
        w_remv = t_field'(w_x);
        for (int m = 1; m < 16; m++) begin
            if (w_x >= 14'(m) * 14'(radix(r_k))) begin
                w_qd   = NIB_W'(m);
                w_remv = t_field'(w_x - 14'(m) * 14'(radix(r_k)));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.action)
                        ACT_ADD:             n_state = S_HORN;
                        ACT_ROUND, ACT_CEIL: n_state = S_RND;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_HORN: begin
                if (r_k == r_unit) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = w_sum[ACC_W] ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1) && r_k == UNIT_HOUR) begin
                    n_state = S_EMIT;
                end
            end
            S_RND: begin
                if (r_k == r_unit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_ofree) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_f      = r_f;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_k      = r_k;
        n_step   = r_step;
        n_unit   = r_unit;
        n_act    = r_act;
        n_delta  = r_delta;
        n_status = r_status;
        o_pop    = 1'b0;
        w_emit   = 1'b0;
        w_inc    = 1'b0;
        w_carry  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    n_unit  = i_head.unit;
                    n_act   = i_head.action;
                    n_delta = i_head.delta;
                    unique case (i_head.action)
                        ACT_ADD: begin
                            o_pop = 1'b1;
                            n_acc = ACC_W'(r_f[5]);
                            n_k   = UNIT_HOUR;
                        end
                        ACT_ROUND, ACT_CEIL: begin
                            o_pop    = 1'b1;
                            n_k      = UNIT_NS;
                            n_status = ST_OK;
                        end
                        default: begin
                            o_pop    = w_ofree;
                            w_emit   = w_ofree;
                            n_status = ST_OK;
                            if (w_ofree) begin
                                if (i_head.action == ACT_LOAD) begin
                                    if (i_head.load_ok) begin
                                        for (int k = 0; k < NUM_FIELDS; k++) begin
                                            n_f[k] = i_head.load[k];
                                        end
                                    end else begin
                                        n_status = ST_BADLOAD;
                                    end
                                end else if (i_head.action == ACT_FLOOR) begin
                                    for (int k = 0; k < NUM_FIELDS; k++) begin
                                        if (3'(k) < i_head.unit) begin
                                            n_f[k] = '0;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_HORN: begin
                if (r_k != r_unit) begin
                    n_acc = mul_radix(r_acc, r_k - 3'd1) + ACC_W'(w_rd);
                    n_k   = r_k - 3'd1;
                end
            end
            S_SUM: begin
                n_rem  = '0;
                n_step = '0;
                if (w_sum[ACC_W]) begin
                    n_status = ST_NEG;
                end else begin
                    n_status = ST_OK;
                    n_acc    = w_sum[ACC_W-1:0];
                end
            end
            S_DIV: begin
                n_acc  = {r_acc[ACC_W-NIB_W-1:0], w_qd};
                n_rem  = w_remv;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_f[r_k] = w_remv;
                    n_rem    = '0;
                    n_step   = '0;
                    if (r_k != UNIT_HOUR) begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            S_RND: begin
                if (r_k != r_unit) begin
                    w_inc    = (r_act == ACT_ROUND) ? (w_rd >= (radix(r_k) >> 1))
                                                    : (w_rd != '0);
                    n_f[r_k] = '0;
                    w_carry  = w_inc;
                    for (int j = 0; j < NUM_FIELDS; j++) begin
                        if (3'(j) > r_k && w_carry) begin
                            if (r_f[j] == radix(3'(j)) - 10'd1) begin
                                n_f[j] = '0;
                            end else begin
                                n_f[j]  = r_f[j] + 10'd1;
                                w_carry = 1'b0;
                            end
                        end
                    end
                    n_k = r_k + 3'd1;
                end
            end
            S_EMIT: begin
                w_emit = w_ofree;
            end
            default: ;
        endcase
    end

    assign n_out_valid = w_emit ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_f[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_f         <= n_f;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_k      <= n_k;
        r_step   <= n_step;
        r_unit   <= n_unit;
        r_act    <= n_act;
        r_delta  <= n_delta;
        r_status <= n_status;
        if (w_emit) begin
            r_out_f      <= n_f;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {1'b0, r_out_f[0], r_out_f[1], r_out_f[2],
                              r_out_f[3][5:0], r_out_f[4][5:0], r_out_f[5][4:0]};

endmodule

/* rtl/time_of_day_add_round.sv */
// ----------------------------------------------------------------------------
// time_of_day_add_round
// Time-of-day register with load, mixed-radix add, round, ceil and floor.
// ----------------------------------------------------------------------------
// Load, floor and no-op are done on decode in the idle state and run back to
// back. Round and ceil decode, then take a step per field below the unit and
// a final step check, then present the result. Add decodes, folds the upper
// fields into a count, checks the sign of count plus delta, then divides the
// count field by field from the unit up to the hour in the radix-16 constant
// divider and presents the result. A total below zero skips the divider.
// A stalled output makes the back end wait until the output register is free.
// A two-entry queue keeps accepting transfers until it is full while the back
// end works and the output register holds a result.
// ----------------------------------------------------------------------------
module time_of_day_add_round
    import tdoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // unit[2:0], delta[50:3], load_hour[55:51], load_minute[61:56],
    // load_second[67:62], load_milli[77:68], load_micro[87:78], load_nano[97:88]
    input  logic [SDATA_W-1:0] i_s_axis_tdata,
    // action[2:0]
    input  logic [2:0]         i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // out_hour[4:0], out_minute[10:5], out_second[16:11], out_milli[26:17],
    // out_micro[36:27], out_nano[46:37]
    output logic [MDATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]         o_m_axis_tuser
);

    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;

    tdoar_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_head          (w_head),
        .o_head_valid    (w_head_valid),
        .i_pop           (w_pop)
    );

    tdoar_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_valid    (w_head_valid),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

/* rtl/tdoar_checker.sv */
// ----------------------------------------------------------------------------
// tdoar_checker
// Port-level checks on the time-of-day block, bound to the top level.
// ----------------------------------------------------------------------------
module tdoar_checker
    import tdoar_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [SDATA_W-1:0] i_s_axis_tdata,
    input logic [2:0]         i_s_axis_tuser,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [MDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]         o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3)
        else $error("undefined status");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[4:0] < 5'd24 && o_m_axis_tdata[10:5] < 6'd60
            && o_m_axis_tdata[16:11] < 6'd60 && o_m_axis_tdata[26:17] < 10'd1000
            && o_m_axis_tdata[36:27] < 10'd1000 && o_m_axis_tdata[46:37] < 10'd1000)
        else $error("result field out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind time_of_day_add_round tdoar_checker u_chk (.*);
